// ===== sv/xtea_pkg.sv =====
// Shared types, constants and helper functions for the XTEA block cipher.
// Used by every module of the block; depends on nothing.
package xtea_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned NUM_KEYS       = 4;
    localparam int unsigned KEY_IDX_W      = 2;
    localparam int unsigned ROUNDS_DEFAULT = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Key word 3 is the most significant element, key word 0 the least.
    localparam logic [NUM_KEYS-1:0][WORD_W-1:0] KEY_RESET = {
        32'hA59E7268, 32'hBD39AEE3, 32'h7506499E, 32'h53527737
    };

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } blk_t;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } res_t;

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // Round sum after k steps of delta, modulo 2^32. Only called with constants.
    function automatic logic [WORD_W-1:0] sum_at(input int unsigned k);
        logic [WORD_W-1:0] kk;
        kk = k[WORD_W-1:0];
        return kk * DELTA;
    endfunction

endpackage

// ===== sv/xtea_block_cipher.sv =====
// Top level of the pipelined XTEA block cipher: key registers, round stages
// and output queue. Depends on xtea_pkg, xtea_hround and xtea_obuf.
//
// Usage: a block (cmd, left_half, right_half) enters on the in_valid/in_ready
// channel; cmd selects encryption or decryption. The result block leaves on
// the out_valid/out_ready channel as out_left/out_right, in input order.
// The 128-bit key lives in four 32-bit registers written on the cfg channel
// (cfg_index selects the word, cfg_ready is always high); write them only
// while no transaction is in flight.
// Each half round is one register stage, and the result then passes through
// the output queue.
// Throughput: one block per cycle while the output queue is not full; every
// half-round stage accepts a new block each cycle unless the pipeline holds.
// Reset clears all valid bits and the queue, and loads the default key.
// When the receiver stalls, the two-entry output queue fills and then the
// whole pipeline holds; in_ready falls only while the queue is full.
module xtea_block_cipher #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] left_half,
    input  logic [31:0] right_half,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_left,
    output logic [31:0] out_right,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned STEPS = 2 * ROUNDS;

    xtea_pkg::key_t key_reg, key_next;

    logic           stage_en;
    logic           valid_pipe [0:STEPS];
    xtea_pkg::blk_t data_pipe  [0:STEPS];
    xtea_pkg::res_t last_res;
    xtea_pkg::res_t head_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            key_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= xtea_pkg::KEY_RESET;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign in_ready      = stage_en;
    assign valid_pipe[0] = in_valid;
    assign data_pipe[0]  = {cmd, left_half, right_half};

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_step
            xtea_hround #(
                .ROUNDS (ROUNDS),
                .STEP   (g)
            ) u_hround (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (stage_en),
                .key       (key_reg),
                .valid_in  (valid_pipe[g]),
                .data_in   (data_pipe[g]),
                .valid_out (valid_pipe[g+1]),
                .data_out  (data_pipe[g+1])
            );
        end
    endgenerate

    assign last_res.left  = data_pipe[STEPS].left;
    assign last_res.right = data_pipe[STEPS].right;

    xtea_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (valid_pipe[STEPS]),
        .push_ready (stage_en),
        .push_data  (last_res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (head_res)
    );

    assign out_left  = head_res.left;
    assign out_right = head_res.right;

    // The pipeline only holds when the output queue has results waiting.
    a_hold_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_en |-> out_valid)
        else $error("pipeline held with no result at the output");

    // While held, the last stage keeps its transaction.
    a_hold_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_en |=> $stable(valid_pipe[STEPS]))
        else $error("last stage valid changed during a hold");

    // The key changes only through a configuration transaction.
    a_key_only_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> $stable(key_reg))
        else $error("key changed without a configuration write");

endmodule

// ===== sv/xtea_hround.sv =====
// One half-round pipeline stage of XTEA: updates one half of the block.
// Depends on xtea_pkg for the block type, the mixing function and the sums.
module xtea_hround #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEFAULT,
    parameter int unsigned STEP   = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  xtea_pkg::key_t key,
    input  logic           valid_in,
    input  xtea_pkg::blk_t data_in,
    output logic           valid_out,
    output xtea_pkg::blk_t data_out
);

    localparam int unsigned RND    = STEP / 2;
    localparam bit          SECOND = (STEP % 2) == 1;

    // Encryption updates left then right; decryption right then left.
    localparam logic [31:0] ENC_SUM = SECOND ? xtea_pkg::sum_at(RND + 1)
                                             : xtea_pkg::sum_at(RND);
    localparam logic [31:0] DEC_SUM = SECOND ? xtea_pkg::sum_at(ROUNDS - RND - 1)
                                             : xtea_pkg::sum_at(ROUNDS - RND);
    localparam logic [1:0]  ENC_KI  = SECOND ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam logic [1:0]  DEC_KI  = SECOND ? DEC_SUM[1:0]   : DEC_SUM[12:11];

    logic           valid_reg, valid_next;
    xtea_pkg::blk_t data_reg, data_next;

    logic        is_enc;
    logic        tgt_left;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] sum_sel;
    logic [31:0] key_sel;
    logic [31:0] f_val;
    logic [31:0] upd;

    always_comb
    begin
        is_enc   = (data_in.cmd == xtea_pkg::CMD_ENCRYPT);
        tgt_left = is_enc ? !SECOND : SECOND;
        src      = tgt_left ? data_in.right : data_in.left;
        dst      = tgt_left ? data_in.left  : data_in.right;
        sum_sel  = is_enc ? ENC_SUM : DEC_SUM;
        key_sel  = is_enc ? key[ENC_KI] : key[DEC_KI];
        f_val    = xtea_pkg::mix_word(src) ^ (sum_sel + key_sel);
        upd      = is_enc ? (dst + f_val) : (dst - f_val);

        data_next       = data_in;
        if (tgt_left)
        begin
            data_next.left = upd;
        end
        else
        begin
            data_next.right = upd;
        end
        valid_next = valid_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== sv/xtea_obuf.sv =====
// Two-entry output queue that decouples the cipher pipeline from the receiver.
// Depends on xtea_pkg for the result type.
module xtea_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  xtea_pkg::res_t push_data,
    output logic           out_valid,
    input  logic           out_ready,
    output xtea_pkg::res_t out_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    xtea_pkg::res_t mem [0:1];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // Ready depends on the fill count alone, so the receiver's ready never
    // reaches the input side combinationally.
    assign push_ready = (count_reg != DEPTH);
    assign out_valid  = (count_reg != 2'd0);
    assign out_data   = mem[rd_ptr_reg];

    always_comb
    begin
        push        = push_valid && push_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== bench/xtea_result_checker.sv =====
// Result checker for the XTEA block cipher: watches the block, key and result
// channels, predicts each result block and compares it. Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_result_checker #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] left_half,
    input  logic [31:0] right_half,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_left,
    input  logic [31:0] out_right,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam logic [31:0] GOLDEN      = 32'h9E3779B9;
    localparam logic [31:0] ROUND_COUNT = ROUNDS;
    localparam int          REPORT_MAX  = 10;

    xtea_pkg::key_t cipher_key;
    xtea_pkg::res_t expected_blocks[$];
    int             failures;

    function automatic logic [31:0] feistel(input logic [31:0] w);
        return ({w[27:0], 4'b0000} ^ {5'b00000, w[31:5]}) + w;
    endfunction

    function automatic xtea_pkg::res_t cipher_block(input logic op,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b,
                                                    input xtea_pkg::key_t k);
        logic [31:0]    l;
        logic [31:0]    r;
        logic [31:0]    s;
        xtea_pkg::res_t res;
        l = a;
        r = b;
        if (op == xtea_pkg::CMD_DECRYPT)
        begin
            s = ROUND_COUNT * GOLDEN;
            for (int i = 0; i < ROUNDS; i++)
            begin
                r = r - (feistel(l) ^ (s + k[s[12:11]]));
                s = s - GOLDEN;
                l = l - (feistel(r) ^ (s + k[s[1:0]]));
            end
        end
        else
        begin
            s = '0;
            for (int i = 0; i < ROUNDS; i++)
            begin
                l = l + (feistel(r) ^ (s + k[s[1:0]]));
                s = s + GOLDEN;
                r = r + (feistel(l) ^ (s + k[s[12:11]]));
            end
        end
        res.left  = l;
        res.right = r;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xtea_pkg::res_t want;
        if (!rst_n)
        begin
            cipher_key = xtea_pkg::KEY_RESET;
            expected_blocks.delete();
            failures = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // The key in effect for a block is the one held before this edge.
            if (in_valid && in_ready)
                expected_blocks.push_back(cipher_block(cmd, left_half, right_half,
                                                       cipher_key));
            if (cfg_valid && cfg_ready)
                cipher_key[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    if (failures < REPORT_MAX)
                        $display("unexpected result transaction: %08h %08h",
                                 out_left, out_right);
                    failures++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (want.left !== out_left || want.right !== out_right)
                    begin
                        if (failures < REPORT_MAX)
                            $display("mismatch: expected %08h %08h, got %08h %08h",
                                     want.left, want.right, out_left, out_right);
                        failures++;
                    end
                end
            end
            fail_count <= failures;
            pending <= expected_blocks.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the XTEA block cipher bench: clock, reset, stimulus and verdict.
// Depends on xtea_pkg, xtea_block_cipher and xtea_result_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned ROUNDS      = 32;
    localparam int          LIMIT       = 500000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASES      = 5;
    localparam int          PHASE_ITEMS = 186;

    localparam logic [1:0] KEY_WORD0 = 2'd0;
    localparam logic [1:0] KEY_WORD1 = 2'd1;
    localparam logic [1:0] KEY_WORD2 = 2'd2;
    localparam logic [1:0] KEY_WORD3 = 2'd3;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        cmd        = xtea_pkg::CMD_ENCRYPT;
    logic [31:0] left_half  = '0;
    logic [31:0] right_half = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] out_left;
    logic [31:0] out_right;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = KEY_WORD0;
    logic [31:0] cfg_data   = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int cycle_count = 0;

    always #6 clk = ~clk;

    xtea_block_cipher #(.ROUNDS(ROUNDS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .left_half  (left_half),
        .right_half (right_half),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_left   (out_left),
        .out_right  (out_right),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    xtea_result_checker #(.ROUNDS(ROUNDS)) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .left_half  (left_half),
        .right_half (right_half),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_left   (out_left),
        .out_right  (out_right),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, plus long hold-offs on request.
    initial
    begin : receiver
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_asked > holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Leaves valid high after acceptance so back-to-back blocks need no toggle.
    task automatic offer_block(input logic op, input logic [31:0] l, input logic [31:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        left_half  <= l;
        right_half <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_key_word(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_key(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
        write_key_word(KEY_WORD0, w0);
        write_key_word(KEY_WORD1, w1);
        write_key_word(KEY_WORD2, w2);
        write_key_word(KEY_WORD3, w3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly uniform words, with the extremes and single-bit words mixed in.
    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks under the reset key.
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        wait_drained();

        // Extreme keys.
        load_key(32'h0, 32'h0, 32'h0, 32'h0);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        offer_block(xtea_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_block(xtea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            case (phase)
                1: load_key(32'h0, 32'hFFFF_FFFF, $urandom, $urandom);
                4: load_key(xtea_pkg::KEY_RESET[0], xtea_pkg::KEY_RESET[1],
                            xtea_pkg::KEY_RESET[2], xtea_pkg::KEY_RESET[3]);
                default: load_key($urandom, $urandom, $urandom, $urandom);
            endcase
            // With little or no idling, a long hold-off fills the pipeline and stalls input.
            if (phase == 0 || phase == 3)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_block($urandom_range(1) ? xtea_pkg::CMD_DECRYPT
                                              : xtea_pkg::CMD_ENCRYPT,
                            random_word(), random_word());
            wait_drained();
        end

        repeat (2 * ROUNDS + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/xtea_pkg.sv
sv/xtea_hround.sv
sv/xtea_obuf.sv
sv/xtea_block_cipher.sv
bench/xtea_result_checker.sv
bench/testbench.sv
